>>> rtl/tfba_pkg.sv
// Package for the typed free-list and bump allocator.
// Holds sizing constants, the free-list entry type, controller/datapath
// command and status structs, codes and the node size function. No dependencies.
package tfba_pkg;

	localparam int PAGE_BYTES      = 1024;
	localparam int MAX_PAGES       = 16;
	localparam int FREE_DEPTH_DEF  = 64;

	localparam int PAGE_W          = 4;
	localparam int OFFSET_W        = 10;
	localparam int SIZE_W          = 11;
	localparam int NODE_W          = SIZE_W + 1;
	localparam int FILL_W          = $clog2(PAGE_BYTES + 1);
	localparam int PAGE_IDX_W      = $clog2(MAX_PAGES);
	localparam int PAGE_CNT_W      = $clog2(MAX_PAGES + 1);
	localparam int SLOTS_PER_PAGE  = PAGE_BYTES / 8;
	localparam int SLOT_COUNT      = MAX_PAGES * SLOTS_PER_PAGE;
	localparam int SLOT_AW         = $clog2(SLOT_COUNT);
	localparam int SLOT_SHIFT      = $clog2(8);

	localparam logic [2:0] ROUND_MASK = 3'b111;

	localparam logic [SIZE_W-1:0] PAIR_BYTES_RST   = SIZE_W'(24);
	localparam logic [SIZE_W-1:0] VECTOR_BYTES_RST = SIZE_W'(32);

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [1:0] OUT_OK   = 2'd0;
	localparam logic [1:0] OUT_OOM  = 2'd1;
	localparam logic [1:0] OUT_FULL = 2'd2;

	localparam logic REG_PAIR   = 1'b0;
	localparam logic REG_VECTOR = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0]   page;
		logic [OFFSET_W-1:0] offset;
		logic                kind;
	} free_entry_t;

	typedef struct packed {
		logic       load;
		logic       rel_rd;
		logic       push;
		logic       scan_init;
		logic       scan;
		logic       hit_lat;
		logic       last_rd;
		logic       swap;
		logic       page_next;
		logic       take;
		logic       open;
		logic       emit;
		logic [1:0] code;
	} tfba_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic hit;
		logic miss;
		logic too_big;
		logic in_open;
		logic fits;
		logic can_open;
	} tfba_status_t;

	function automatic logic [NODE_W-1:0] node_size(input logic [SIZE_W-1:0] bytes);
		logic [NODE_W-1:0] v;
		v = (bytes == '0) ? NODE_W'(1) : {1'b0, bytes};
		if (v[2:0] != 3'b000)
			v = v + NODE_W'(8) - {{(NODE_W-3){1'b0}}, v[2:0] & ROUND_MASK};
		return v;
	endfunction

endpackage

>>> rtl/typed_free_list_bump_allocator_top.sv
// Top level of the typed free-list and bump allocator.
// Depends on tfba_pkg, tfba_cfg, tfba_ctrl, tfba_dp (and tfba_ram below it).
//
// Usage:
//   Command channel: a transfer is taken when start is high and busy is low.
//   func selects allocate or release; object_kind, release_page and
//   release_offset carry the operands. Each command yields one result,
//   shown for one cycle with done high on given_page, given_offset, outcome.
//   The receiver cannot stall; results must be taken in the done cycle.
//   APB port: pair_node_bytes at 0x0, vector_node_bytes at 0x4, pready
//   tied high; write only while the block is idle.
//   Sequence: a release reads the slot kind RAM, then pushes the entry;
//     a release on a full list is answered with outcome full, no push.
//   An allocate scans the free list for an entry of its kind; on a hit the
//     last entry is read and moved into the hit slot. On a miss or an empty
//     list the open pages are searched in order, else a new page opens.
//   The free-list scan reads one entry per cycle from its RAM and the page
//   search checks one page fill register per cycle; these bound the rate.
//   Reset: free list empty, no page open, size registers 24 and 32.
//   No clearing pass is needed; the block accepts a command right away.
module typed_free_list_bump_allocator_top
	import tfba_pkg::*;
#(
	parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic                object_kind,
	input  logic [PAGE_W-1:0]   release_page,
	input  logic [OFFSET_W-1:0] release_offset,
	output logic                done,
	output logic [PAGE_W-1:0]   given_page,
	output logic [OFFSET_W-1:0] given_offset,
	output logic [1:0]          outcome
);

	logic [SIZE_W-1:0] pair_bytes;
	logic [SIZE_W-1:0] vector_bytes;
	tfba_cmd_t         cmd;
	tfba_status_t      status;

	tfba_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pair_bytes  (pair_bytes),
		.vector_bytes(vector_bytes)
	);

	tfba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	tfba_dp #(.FREE_DEPTH(FREE_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.pair_bytes    (pair_bytes),
		.vector_bytes  (vector_bytes),
		.object_kind   (object_kind),
		.release_page  (release_page),
		.release_offset(release_offset),
		.done          (done),
		.given_page    (given_page),
		.given_offset  (given_offset),
		.outcome       (outcome)
	);

endmodule

>>> rtl/tfba_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module tfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tfba_cfg.sv
// APB register file holding the two node size registers.
// Depends on tfba_pkg.
module tfba_cfg
	import tfba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] pair_bytes,
	output logic [SIZE_W-1:0] vector_bytes
);

	logic [SIZE_W-1:0] pair_q;
	logic [SIZE_W-1:0] vector_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q   <= PAIR_BYTES_RST;
			vector_q <= VECTOR_BYTES_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_PAIR)
				pair_q <= pwdata[SIZE_W-1:0];
			else
				vector_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_PAIR)
			prdata = {{(32-SIZE_W){1'b0}}, pair_q};
		else
			prdata = {{(32-SIZE_W){1'b0}}, vector_q};
	end

	assign pair_bytes   = pair_q;
	assign vector_bytes = vector_q;

endmodule

>>> rtl/tfba_ctrl.sv
// Controller state machine of the allocator.
// Sequences release, free-list scan and page search; depends on tfba_pkg.
module tfba_ctrl
	import tfba_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         func,
	input  tfba_status_t status,
	output tfba_cmd_t    cmd,
	output logic         busy
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_REL_RD  = 3'd1;
	localparam logic [2:0] ST_REL_WR  = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_LAST_RD = 3'd4;
	localparam logic [2:0] ST_SWAP    = 3'd5;
	localparam logic [2:0] ST_PAGE    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.code = OUT_OK;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (func == FUNC_RELEASE) begin
						if (status.full) begin
							cmd.emit = 1'b1;
							cmd.code = OUT_FULL;
						end else begin
							state_d = ST_REL_RD;
						end
					end else if (status.empty) begin
						state_d = ST_PAGE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_REL_RD: begin
				cmd.rel_rd = 1'b1;
				state_d = ST_REL_WR;
			end
			ST_REL_WR: begin
				cmd.push = 1'b1;
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit) begin
					cmd.hit_lat = 1'b1;
					state_d = ST_LAST_RD;
				end else if (status.miss) begin
					state_d = ST_PAGE;
				end
			end
			ST_LAST_RD: begin
				cmd.last_rd = 1'b1;
				state_d = ST_SWAP;
			end
			ST_SWAP: begin
				cmd.swap = 1'b1;
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PAGE: begin
				if (status.too_big) begin
					cmd.emit = 1'b1;
					cmd.code = OUT_OOM;
					state_d = ST_IDLE;
				end else if (status.in_open) begin
					if (status.fits) begin
						cmd.take = 1'b1;
						cmd.emit = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.page_next = 1'b1;
					end
				end else if (status.can_open) begin
					cmd.take = 1'b1;
					cmd.open = 1'b1;
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.emit = 1'b1;
					cmd.code = OUT_OOM;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> rtl/tfba_dp.sv
// Datapath of the allocator: free-list RAM, slot kind RAM, page fill
// registers, scan counters and result registers. Depends on tfba_pkg, tfba_ram.
module tfba_dp
	import tfba_pkg::*;
#(
	parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tfba_cmd_t           cmd,
	output tfba_status_t        status,
	input  logic [SIZE_W-1:0]   pair_bytes,
	input  logic [SIZE_W-1:0]   vector_bytes,
	input  logic                object_kind,
	input  logic [PAGE_W-1:0]   release_page,
	input  logic [OFFSET_W-1:0] release_offset,
	output logic                done,
	output logic [PAGE_W-1:0]   given_page,
	output logic [OFFSET_W-1:0] given_offset,
	output logic [1:0]          outcome
);

	localparam int FIW = $clog2(FREE_DEPTH);
	localparam int FCW = $clog2(FREE_DEPTH + 1);

	logic                kind_q;
	logic [PAGE_W-1:0]   rpage_q;
	logic [OFFSET_W-1:0] roff_q;
	logic [NODE_W-1:0]   size_q;
	logic                in_range_q;

	logic [FCW-1:0]      count_q;
	logic [FCW-1:0]      scan_idx_q;
	logic                chk_valid_s1;
	logic [FIW-1:0]      chk_idx_s1;
	logic [FIW-1:0]      hit_idx_q;
	free_entry_t         got_q;

	logic [FILL_W-1:0]     fill_q [MAX_PAGES];
	logic [PAGE_CNT_W-1:0] pages_open_q;
	logic [PAGE_CNT_W-1:0] p_q;

	logic                done_q;
	logic [PAGE_W-1:0]   page_out_q;
	logic [OFFSET_W-1:0] off_out_q;
	logic [1:0]          code_q;

	logic                fl_we;
	logic [FIW-1:0]      fl_waddr;
	free_entry_t         fl_wdata;
	logic [FIW-1:0]      fl_raddr;
	free_entry_t         fl_rdata;

	logic                sk_we;
	logic [SLOT_AW-1:0]  sk_waddr;
	logic [SLOT_AW-1:0]  sk_raddr;
	logic                sk_rdata;

	logic [PAGE_CNT_W-1:0] take_p;
	logic [FILL_W-1:0]     take_off;
	logic [FILL_W-1:0]     cur_fill;
	logic [NODE_W:0]       fill_sum;

	always_comb begin
		fl_raddr = scan_idx_q[FIW-1:0];
		if (cmd.scan_init)
			fl_raddr = '0;
		else if (cmd.last_rd)
			fl_raddr = FIW'(count_q - FCW'(1));
	end

	always_comb begin
		fl_we    = cmd.push | cmd.swap;
		fl_waddr = cmd.swap ? hit_idx_q : count_q[FIW-1:0];
		if (cmd.swap)
			fl_wdata = fl_rdata;
		else
			fl_wdata = '{page: rpage_q, offset: roff_q, kind: in_range_q & sk_rdata};
	end

	tfba_ram #(.WIDTH($bits(free_entry_t)), .DEPTH(FREE_DEPTH)) u_free_ram (
		.clk  (clk),
		.we   (fl_we),
		.waddr(fl_waddr),
		.wdata(fl_wdata),
		.raddr(fl_raddr),
		.rdata(fl_rdata)
	);

	assign cur_fill = fill_q[p_q[PAGE_IDX_W-1:0]];
	assign fill_sum = (NODE_W+1)'(cur_fill) + (NODE_W+1)'(size_q);
	assign take_p   = cmd.open ? pages_open_q : p_q;
	assign take_off = cmd.open ? '0 : cur_fill;

	assign sk_raddr = {rpage_q[PAGE_IDX_W-1:0], roff_q[OFFSET_W-1:SLOT_SHIFT]};
	assign sk_waddr = {take_p[PAGE_IDX_W-1:0], take_off[OFFSET_W-1:SLOT_SHIFT]};
	assign sk_we    = cmd.take;

	tfba_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(kind_q),
		.raddr(sk_raddr),
		.rdata(sk_rdata)
	);

	always_comb begin
		status.full     = (count_q == FCW'(FREE_DEPTH));
		status.empty    = (count_q == '0);
		status.hit      = chk_valid_s1 & (fl_rdata.kind == kind_q);
		status.miss     = ~chk_valid_s1;
		status.too_big  = (32'(size_q) > 32'(PAGE_BYTES));
		status.in_open  = (p_q < pages_open_q);
		status.fits     = (32'(fill_sum) <= 32'(PAGE_BYTES));
		status.can_open = (32'(pages_open_q) < 32'(MAX_PAGES));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= object_kind;
			rpage_q    <= release_page;
			roff_q     <= release_offset;
			size_q     <= node_size(object_kind ? vector_bytes : pair_bytes);
			in_range_q <= (32'(release_page) < 32'(MAX_PAGES)) &&
				(32'(release_offset) < 32'(PAGE_BYTES));
		end
		if (cmd.hit_lat) begin
			got_q     <= fl_rdata;
			hit_idx_q <= chk_idx_s1;
		end
		if (cmd.emit) begin
			code_q <= cmd.code;
			if (cmd.swap) begin
				page_out_q <= got_q.page;
				off_out_q  <= got_q.offset;
			end else if (cmd.take) begin
				page_out_q <= take_p[PAGE_W-1:0];
				off_out_q  <= take_off[OFFSET_W-1:0];
			end else begin
				page_out_q <= '0;
				off_out_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			scan_idx_q   <= '0;
			chk_valid_s1 <= 1'b0;
			chk_idx_s1   <= '0;
			pages_open_q <= '0;
			p_q          <= '0;
			done_q       <= 1'b0;
			for (int i = 0; i < MAX_PAGES; i++)
				fill_q[i] <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load)
				p_q <= '0;
			else if (cmd.page_next)
				p_q <= p_q + PAGE_CNT_W'(1);
			if (cmd.scan_init) begin
				scan_idx_q   <= FCW'(1);
				chk_valid_s1 <= 1'b1;
				chk_idx_s1   <= '0;
			end else if (cmd.scan) begin
				scan_idx_q   <= scan_idx_q + FCW'(1);
				chk_valid_s1 <= (scan_idx_q < count_q);
				chk_idx_s1   <= scan_idx_q[FIW-1:0];
			end
			if (cmd.push)
				count_q <= count_q + FCW'(1);
			else if (cmd.swap)
				count_q <= count_q - FCW'(1);
			if (cmd.take)
				fill_q[take_p[PAGE_IDX_W-1:0]] <= take_off + FILL_W'(size_q);
			if (cmd.open)
				pages_open_q <= pages_open_q + PAGE_CNT_W'(1);
		end
	end

	assign done         = done_q;
	assign given_page   = page_out_q;
	assign given_offset = off_out_q;
	assign outcome      = code_q;

endmodule
